// ----- rtl/core/itrs_pkg.sv -----
// Shared constants, types and helper functions for the radix string converter.
`default_nettype none

package itrs_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int DATA_W      = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam int CNT_W       = $clog2(VALUE_WIDTH);
    localparam int LEN_W       = CNT_W + 1;
    localparam int RADIX_W     = 6;
    localparam int CHAR_W      = 7;
    localparam int SHIFT_W     = 3;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] ALPHA_START = 6'd10;
    localparam logic [CHAR_W-1:0]  SIGN_CHAR   = 7'd45;
    localparam logic [CHAR_W-1:0]  ZERO_CHAR   = 7'd48;
    localparam logic [CHAR_W-1:0]  ALPHA_CHAR  = 7'd97;
    localparam logic [CHAR_W-1:0]  NO_CHAR     = 7'd0;

    // Divider result as seen by the sequencer
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [RADIX_W-1:0]     remainder;
    } itrs_div_res_t;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_START = 6'b000010,
        ST_WAIT  = 6'b000100,
        ST_SIGN  = 6'b001000,
        ST_DIGIT = 6'b010000,
        ST_EMPTY = 6'b100000
    } itrs_state_t;

    // floor(log2(radix)); bits the quotient loses per division at least
    function automatic logic [SHIFT_W-1:0] radix_shift(input logic [RADIX_W-1:0] r);
        logic [SHIFT_W-1:0] s;
        s = '0;
        if (r[5])      s = 3'd5;
        else if (r[4]) s = 3'd4;
        else if (r[3]) s = 3'd3;
        else if (r[2]) s = 3'd2;
        else if (r[1]) s = 3'd1;
        return s;
    endfunction

    function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < ALPHA_START)
            c = ZERO_CHAR + {1'b0, d};
        else
            c = ALPHA_CHAR + {1'b0, d - ALPHA_START};
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/itrs_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
`default_nettype none

module itrs_div
    import itrs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [LEN_W-1:0]       len,
    input  wire logic [VALUE_WIDTH-1:0] dividend,
    input  wire logic [RADIX_W-1:0]     divisor,
    output itrs_div_res_t               res
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic [VALUE_WIDTH-1:0] q_reg, q_next;
    logic [RADIX_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W:0]       trial;
    logic [RADIX_W:0]       diff;

    assign trial = {rem_reg, d_reg[cnt_reg]};
    assign diff  = trial - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        d_next    = d_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            d_next    = dividend;
            q_next    = '0;
            rem_next  = '0;
            cnt_next  = CNT_W'(len - LEN_W'(1));
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next         = diff[RADIX_W-1:0];
                q_next[cnt_reg]  = 1'b1;
            end
            else
            begin
                rem_next = trial[RADIX_W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        d_reg   <= d_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = q_reg;
    assign res.remainder = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/int_to_radix_string.sv -----
// Signed integer to ASCII text in a configurable base, one text per request.
// Each digit costs one division of len bits: len starts at 32 and drops by
// floor(log2(radix)) per digit, but never below 1.
// One number at a time: a new number is accepted only in the idle state,
// once the previous text has been handed to the output register.
// Asynchronous active-low reset; radix resets to 10, no clearing pass.
`default_nettype none

module int_to_radix_string
    import itrs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [DATA_W-1:0]  s_tdata,   // [31:0] number
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [7:0]              m_tdata,   // [6:0] char_code, [7] zero
    output logic                    m_tlast,   // last_char
    output logic                    m_tuser,   // empty_text
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [RADIX_W-1:0] cfg_data   // radix
);

    itrs_state_t            state_reg, state_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   neg_reg, neg_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic [SHIFT_W-1:0]     shift_reg, shift_next;
    logic [LEN_W-1:0]       nd_reg, nd_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [RADIX_W-1:0]     digits_reg [VALUE_WIDTH];
    logic                   dig_we;
    logic                   ov_reg, ov_next;
    logic [CHAR_W-1:0]      oc_reg, oc_next;
    logic                   ol_reg, ol_next;
    logic                   oe_reg, oe_next;
    logic                   div_start;
    itrs_div_res_t          div_res;
    logic                   load_ok;
    logic                   radix_bad;
    logic [VALUE_WIDTH-1:0] num;

    itrs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .len      (len_reg),
        .dividend (mag_reg),
        .divisor  (radix_reg),
        .res      (div_res)
    );

    assign num       = s_tdata[VALUE_WIDTH-1:0];
    assign radix_bad = (radix_reg < RADIX_MIN) || (radix_reg > RADIX_MAX);
    assign load_ok   = !ov_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        len_next   = len_reg;
        shift_next = shift_reg;
        nd_next    = nd_reg;
        idx_next   = idx_reg;
        dig_we     = 1'b0;
        div_start  = 1'b0;
        ov_next    = ov_reg && !m_tready;
        oc_next    = oc_reg;
        ol_next    = ol_reg;
        oe_next    = oe_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (radix_bad)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        neg_next   = num[VALUE_WIDTH-1];
                        // two's complement negate also covers the most negative value
                        mag_next   = num[VALUE_WIDTH-1] ? (~num + VALUE_WIDTH'(1)) : num;
                        len_next   = LEN_W'(VALUE_WIDTH);
                        shift_next = radix_shift(radix_reg);
                        nd_next    = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START:
            begin
                div_start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (div_res.done)
                begin
                    dig_we  = 1'b1;
                    nd_next = nd_reg + LEN_W'(1);
                    if (div_res.quotient == '0)
                    begin
                        idx_next   = nd_reg[CNT_W-1:0];
                        state_next = neg_reg ? ST_SIGN : ST_DIGIT;
                    end
                    else
                    begin
                        mag_next = div_res.quotient;
                        // quotient is below 2^(len - floor(log2 radix))
                        len_next = (len_reg > LEN_W'(shift_reg)) ?
                                   (len_reg - LEN_W'(shift_reg)) : LEN_W'(1);
                        state_next = ST_START;
                    end
                end
            end
            ST_SIGN:
            begin
                if (load_ok)
                begin
                    ov_next    = 1'b1;
                    oc_next    = SIGN_CHAR;
                    ol_next    = 1'b0;
                    oe_next    = 1'b0;
                    state_next = ST_DIGIT;
                end
            end
            ST_DIGIT:
            begin
                if (load_ok)
                begin
                    ov_next = 1'b1;
                    oc_next = digit_char(digits_reg[idx_reg]);
                    ol_next = (idx_reg == '0);
                    oe_next = 1'b0;
                    if (idx_reg == '0)
                        state_next = ST_IDLE;
                    else
                        idx_next = idx_reg - CNT_W'(1);
                end
            end
            ST_EMPTY:
            begin
                if (load_ok)
                begin
                    ov_next    = 1'b1;
                    oc_next    = NO_CHAR;
                    ol_next    = 1'b1;
                    oe_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            radix_reg <= RADIX_RESET;
            ov_reg    <= 1'b0;
            nd_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            nd_reg    <= nd_next;
            if (cfg_valid && cfg_ready)
                radix_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        len_reg   <= len_next;
        shift_reg <= shift_next;
        idx_reg   <= idx_next;
        oc_reg    <= oc_next;
        ol_reg    <= ol_next;
        oe_reg    <= oe_next;
        if (dig_we)
            digits_reg[nd_reg[CNT_W-1:0]] <= div_res.remainder;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {1'b0, oc_reg};
    assign m_tlast  = ol_reg;
    assign m_tuser  = oe_reg;

    // empty text is always a single terminal NUL character
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty result not terminal NUL");

    // input is never ready while the divider reports a finished division
    a_ready_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !div_res.done)
        else $error("input ready during division");

    // digit count never exceeds the value width
    a_nd_range: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= LEN_W'(VALUE_WIDTH))
        else $error("digit store overflow");

    // the final division always leads into sign or digit emission
    a_emit_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WAIT) && div_res.done && (div_res.quotient == '0)
        |=> (state_reg == ST_SIGN) || (state_reg == ST_DIGIT))
        else $error("emission not entered after final division");

endmodule

`default_nettype wire

// ----- dv/int_to_radix_string_test.sv -----
// Testbench for int_to_radix_string: directed table, then random numbers across radix settings.
`timescale 1ns / 1ps

module int_to_radix_string_test
    import itrs_pkg::*;
();

    localparam int IDLE_LIMIT = 20000;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 7'd45;
    localparam logic [CHAR_W-1:0] CHR_ZERO  = 7'd48;
    localparam logic [CHAR_W-1:0] CHR_A     = 7'd97;
    localparam logic [CHAR_W-1:0] CHR_NONE  = 7'd0;
    localparam logic [VALUE_WIDTH-1:0] MOST_NEG = 32'h8000_0000;
    localparam logic [VALUE_WIDTH-1:0] MOST_POS = 32'h7fff_ffff;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
        logic              empty;
    } text_char_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;     // [31:0] number
    logic              m_tvalid;
    logic              m_tready;
    logic [7:0]        m_tdata;     // [6:0] char_code, [7] zero
    logic              m_tlast;     // last_char
    logic              m_tuser;     // empty_text
    logic              cfg_valid;
    logic              cfg_ready;
    logic [RADIX_W-1:0] cfg_data;   // radix

    text_char_t        pending_chars[$];
    logic [RADIX_W-1:0] radix_shadow;
    int                mismatches;
    int                idle_cycles;
    bit                rx_quiet;

    // directed table, one column per queue
    bit                 row_cfg[$];
    logic [RADIX_W-1:0] row_radix[$];
    logic [VALUE_WIDTH-1:0] row_number[$];
    bit                 row_typed[$];
    string              row_text[$];

    int_to_radix_string u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Works out the characters of one number in the given base
    task automatic predict_text(input logic [VALUE_WIDTH-1:0] number,
                                input logic [RADIX_W-1:0] base);
        logic [VALUE_WIDTH-1:0] mag;
        logic [VALUE_WIDTH-1:0] divisor;
        logic [RADIX_W-1:0]     digits[VALUE_WIDTH];
        logic [CHAR_W-1:0]      code;
        int                     count;
        if (base < RADIX_MIN || base > RADIX_MAX)
        begin
            pending_chars.push_back('{code: CHR_NONE, last: 1'b1, empty: 1'b1});
        end
        else
        begin
            // negation wraps the most negative value onto its own magnitude
            mag     = number[VALUE_WIDTH-1] ? -number : number;
            divisor = {{(VALUE_WIDTH-RADIX_W){1'b0}}, base};
            count   = 0;
            do
            begin
                digits[count] = RADIX_W'(mag % divisor);
                mag = mag / divisor;
                count++;
            end
            while (mag != 0);
            if (number[VALUE_WIDTH-1])
                pending_chars.push_back('{code: CHR_MINUS, last: 1'b0, empty: 1'b0});
            for (int i = count - 1; i >= 0; i--)
            begin
                if (digits[i] < 10)
                    code = CHR_ZERO + CHAR_W'(digits[i]);
                else
                    code = CHR_A + CHAR_W'(digits[i] - 10);
                pending_chars.push_back('{code: code, last: (i == 0), empty: 1'b0});
            end
        end
    endtask

    // Typed-in text; an empty string stands for the flagged empty result
    task automatic push_text(input string text);
        byte c;
        if (text.len() == 0)
            pending_chars.push_back('{code: CHR_NONE, last: 1'b1, empty: 1'b1});
        for (int i = 0; i < text.len(); i++)
        begin
            c = text[i];
            pending_chars.push_back('{code: c[6:0], last: (i == text.len() - 1), empty: 1'b0});
        end
    endtask

    task automatic add_row(input bit cfg, input logic [RADIX_W-1:0] radix,
                           input logic [VALUE_WIDTH-1:0] number, input bit typed,
                           input string text);
        row_cfg.push_back(cfg);
        row_radix.push_back(radix);
        row_number.push_back(number);
        row_typed.push_back(typed);
        row_text.push_back(text);
    endtask

    // Called at a falling edge; returns at a falling edge with s_tvalid still high
    task automatic send_number(input logic [VALUE_WIDTH-1:0] number, input int gap,
                               input bit typed, input string text);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= DATA_W'(number);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (typed)
            push_text(text);
        else
            predict_text(number, radix_shadow);
        @(negedge clk);
    endtask

    // Holds off new requests until every expected character has arrived
    task automatic drain_text;
        s_tvalid <= 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_W-1:0] radix);
        drain_text();
        cfg_valid <= 1'b1;
        cfg_data  <= radix;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        radix_shadow = radix;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Receiver: checks each accepted character, then stalls for a drawn number of cycles unless rx_quiet is set
    initial
    begin
        int stall;
        text_char_t want;
        m_tready = 1'b0;
        stall    = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (pending_chars.size() == 0)
                begin
                    $error("unexpected character: code %0d last %0d empty %0d",
                           m_tdata[6:0], m_tlast, m_tuser);
                    mismatches++;
                end
                else
                begin
                    want = pending_chars.pop_front();
                    if (m_tdata[6:0] !== want.code)
                    begin
                        $error("char_code: expected %0d, got %0d", want.code, m_tdata[6:0]);
                        mismatches++;
                    end
                    if (m_tdata[7] !== 1'b0)
                    begin
                        $error("tdata pad: expected 0, got %0d", m_tdata[7]);
                        mismatches++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_char: expected %0d, got %0d", want.last, m_tlast);
                        mismatches++;
                    end
                    if (m_tuser !== want.empty)
                    begin
                        $error("empty_text: expected %0d, got %0d", want.empty, m_tuser);
                        mismatches++;
                    end
                end
                stall = rx_quiet ? 0 : $urandom_range(0, 5);
            end
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("int_to_radix_string_test: errors");
            $finish;
        end
    end

    initial
    begin
        logic [VALUE_WIDTH-1:0] number;
        logic [RADIX_W-1:0]     radix;
        bit                     quiet;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        radix_shadow = RADIX_RESET;
        mismatches   = 0;
        idle_cycles  = 0;
        rx_quiet     = 1'b0;

        // after reset the base is ten
        add_row(0, 0,  0,          1, "0");
        add_row(0, 0,  1,          1, "1");
        add_row(0, 0,  -1,         1, "-1");
        add_row(0, 0,  MOST_POS,   1, "2147483647");
        add_row(0, 0,  MOST_NEG,   1, "-2147483648");
        add_row(0, 0,  12345,      0, "");
        add_row(1, 2,  0,          1, "0");
        add_row(0, 2,  5,          1, "101");
        add_row(0, 2,  MOST_NEG,   0, "");
        add_row(0, 2,  MOST_POS,   0, "");
        add_row(0, 2,  -1,         1, "-1");
        add_row(1, 36, 35,         1, "z");
        add_row(0, 36, -36,        1, "-10");
        add_row(0, 36, MOST_POS,   0, "");
        add_row(0, 36, MOST_NEG,   0, "");
        add_row(1, 16, 255,        1, "ff");
        add_row(0, 16, MOST_NEG,   1, "-80000000");
        add_row(0, 16, 32'hdeadbeef, 0, "");
        // bases outside two to thirty-six, then valid bases again
        add_row(1, 0,  7,          1, "");
        add_row(1, 1,  0,          1, "");
        add_row(1, 37, -1,         1, "");
        add_row(1, 63, MOST_POS,   1, "");
        add_row(1, 8,  32'h55555555, 0, "");
        add_row(1, 3,  32'haaaaaaaa, 0, "");
        add_row(1, 10, 10,         1, "10");

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (row_number[i])
        begin
            if (row_cfg[i])
                set_radix(row_radix[i]);
            send_number(row_number[i], $urandom_range(0, 5), row_typed[i], row_text[i]);
        end

        for (int phase = 0; phase < 8; phase++)
        begin
            if (phase == 0)
                radix = 6'd2;
            else if (phase == 1)
                radix = 6'd36;
            else if ($urandom_range(0, 5) == 0)
                radix = $urandom_range(0, 1) ? RADIX_W'($urandom_range(37, 63))
                                             : RADIX_W'($urandom_range(0, 1));
            else
                radix = RADIX_W'($urandom_range(2, 36));
            set_radix(radix);
            quiet    = ($urandom_range(0, 3) == 0);
            rx_quiet = quiet;
            for (int k = 0; k < 11; k++)
            begin
                case ($urandom_range(0, 5)) inside
                    [0:1]: number = $urandom;
                    2:     number = $urandom_range(0, 40);
                    3:     number = 0 - $urandom_range(0, 40);
                    4:     number = $urandom_range(0, 1) ? MOST_NEG + $urandom_range(0, 3)
                                                         : MOST_POS - $urandom_range(0, 3);
                    default: number = $urandom >> $urandom_range(0, 31);
                endcase
                send_number(number, quiet ? 0 : $urandom_range(0, 5), 0, "");
            end
        end

        s_tvalid <= 1'b0;
        rx_quiet = 1'b0;
        while (pending_chars.size() != 0)
            @(negedge clk);
        repeat (50) @(negedge clk);
        if (mismatches == 0 && pending_chars.size() == 0)
            $display("int_to_radix_string_test: clean");
        else
            $display("int_to_radix_string_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/itrs_pkg.sv
rtl/core/itrs_div.sv
rtl/core/int_to_radix_string.sv
dv/int_to_radix_string_test.sv
